@@ hw/rtl/pddf_pkg.sv @@
// ----------------------------------------------------------------------------
// pddf_pkg
// Widths, character codes and frame positions for the pressure delta
// display formatter.
// ----------------------------------------------------------------------------
package pddf_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int IN_DATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CPU_W       = 24;
  localparam logic [CPU_W-1:0] CPU_RESET = CPU_W'(318169);

  localparam int FRAC_SCALE  = 1000;
  localparam int FRAC_W      = 10;
  localparam int FRAC_MAX    = 999;
  localparam int WHOLE_W     = 7;
  localparam int WHOLE_MAX   = 99;
  localparam int DVD_W       = (SAMPLE_BITS > FRAC_W) ? SAMPLE_BITS : FRAC_W;
  localparam int CNT_W       = $clog2(DVD_W);
  localparam int PROD_W      = CPU_W + FRAC_W;

  // reciprocal multipliers for the digit split
  localparam int RECIP100    = 41;   // x/100 == (x*41)>>12 for x < 1000
  localparam int RECIP100_SH = 12;
  localparam int RECIP10     = 103;  // x/10 == (x*103)>>10 for x < 100
  localparam int RECIP10_SH  = 10;

  localparam int BAR_CELLS   = 16;
  localparam int CHARS       = 17 + BAR_CELLS;
  localparam int POS_W       = $clog2(CHARS);
  localparam int BAR_PROD_W  = $clog2(FRAC_SCALE * (BAR_CELLS + 1));

  localparam int CHAR_W      = 8;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
  localparam logic [CHAR_W-1:0] CH_S     = 8'h53;
  localparam logic [CHAR_W-1:0] CH_I     = 8'h49;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_FULL  = 8'hFF;

  // character positions within a frame
  localparam int POS_SIGN_A  = 0;
  localparam int POS_SIGN_B  = 1;
  localparam int POS_GAP     = 2;
  localparam int POS_TENS_W  = 3;
  localparam int POS_ONES_W  = 4;
  localparam int POS_POINT   = 5;
  localparam int POS_HUND_F  = 6;
  localparam int POS_TENS_F  = 7;
  localparam int POS_ONES_F  = 8;
  localparam int POS_UNIT_SP = 9;
  localparam int POS_UNIT_P  = 10;
  localparam int POS_UNIT_S  = 11;
  localparam int POS_UNIT_I  = 12;
  localparam int POS_UNIT_SE = 13;
  localparam int POS_SIGN_C  = 14;
  localparam int POS_SIGN_D  = 15;
  localparam int POS_NL      = 16;
  localparam int BAR_START   = 17;

endpackage

@@ hw/rtl/pressure_delta_display_formatter_unit.sv @@
// ----------------------------------------------------------------------------
// pressure_delta_display_formatter_unit
// Baseline tracking, delta scaling and LCD frame output for one pressure
// sample per transfer.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  in_      slave      tdata: raw_pressure; tuser: func
//  out_     master     tdata: char_code; tlast: last
//  cfg_     slave      data: counts_per_unit, ready whenever out of reset
//
//  one item passes in turn through the whole-part divide, the scale step,
//  the fraction divide, the digit split and the frame output
//  the bit-serial divider gives one quotient bit a cycle, the frame one
//  character a cycle; output stalls stretch the frame phase only
//  in_tready is high only between frames; synchronous active-low reset
//  restores the default scale and clears the baseline
// ----------------------------------------------------------------------------
module pressure_delta_display_formatter_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pddf_pkg::IN_DATA_W-1:0]   in_tdata,   // [23:0] raw_pressure
  input  logic [0:0]                       in_tuser,   // [0] func
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pddf_pkg::CHAR_W-1:0]      out_tdata,  // [7:0] char_code
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pddf_pkg::CPU_W-1:0]       cfg_data    // [23:0] counts_per_unit
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_W, S_SCALE, S_DIV_F, S_DIG1, S_DIG2, S_DIG3, S_EMIT
  } state_t;

  state_t                             state_r, state_nxt;
  logic [pddf_pkg::CPU_W-1:0]         cpu_r, cpu_nxt;
  logic [pddf_pkg::SAMPLE_BITS-1:0]   baseline_r, baseline_nxt;
  logic                               minus_r, minus_nxt;
  logic [pddf_pkg::DVD_W-1:0]         dvd_r, dvd_nxt;
  logic [pddf_pkg::CPU_W-1:0]         rem_r, rem_nxt;
  logic [pddf_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [pddf_pkg::WHOLE_W-1:0]       whole_r, whole_nxt;
  logic [pddf_pkg::FRAC_W-1:0]        frac_r, frac_nxt;
  logic [3:0]                         hund_r, hund_nxt;
  logic [3:0]                         wtens_r, wtens_nxt;
  logic [3:0]                         wones_r, wones_nxt;
  logic [6:0]                         r100_r, r100_nxt;
  logic [3:0]                         ftens_r, ftens_nxt;
  logic [pddf_pkg::POS_W-1:0]         pos_r, pos_nxt;
  logic                               out_tvalid_r, out_tvalid_nxt;
  logic [pddf_pkg::CHAR_W-1:0]        out_tdata_r, out_tdata_nxt;
  logic                               out_tlast_r, out_tlast_nxt;

  logic [pddf_pkg::SAMPLE_BITS-1:0]   sample;
  logic [pddf_pkg::SAMPLE_BITS-1:0]   base_sel;
  logic                               sample_ge;
  logic [pddf_pkg::SAMPLE_BITS-1:0]   delta;
  logic [pddf_pkg::CPU_W:0]           trial;
  logic [pddf_pkg::CPU_W:0]           trial_sub;
  logic                               trial_ge;
  logic [pddf_pkg::CPU_W-1:0]         rem_step;
  logic [pddf_pkg::DVD_W-1:0]         dvd_step;
  logic [pddf_pkg::PROD_W-1:0]        scale_prod;
  logic                               cpu_zero;
  logic [15:0]                        hund_prod;
  logic [13:0]                        wtens_prod;
  logic [13:0]                        ftens_prod;
  logic [3:0]                         fones;
  logic [pddf_pkg::POS_W-1:0]         cell_idx;
  logic [pddf_pkg::BAR_PROD_W-1:0]    cell_lhs;
  logic [pddf_pkg::BAR_PROD_W-1:0]    cell_rhs;
  logic [pddf_pkg::CHAR_W-1:0]        sign_ch;
  logic [pddf_pkg::CHAR_W-1:0]        frame_ch;
  logic                               out_free;
  logic                               in_xfer;

  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign cfg_ready  = rst_n;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign cpu_zero   = (cpu_r == '0);

  // baseline capture and absolute difference
  assign sample    = in_tdata[pddf_pkg::SAMPLE_BITS-1:0];
  assign base_sel  = (in_tuser[0] || baseline_r == '0) ? sample : baseline_r;
  assign sample_ge = (sample >= base_sel);
  assign delta     = sample_ge ? (sample - base_sel) : (base_sel - sample);

  // shared restoring divide step
  assign trial     = {rem_r, dvd_r[pddf_pkg::DVD_W-1]};
  assign trial_sub = trial - {1'b0, cpu_r};
  assign trial_ge  = (trial >= {1'b0, cpu_r});
  assign rem_step  = trial_ge ? trial_sub[pddf_pkg::CPU_W-1:0]
                              : trial[pddf_pkg::CPU_W-1:0];
  assign dvd_step  = {dvd_r[pddf_pkg::DVD_W-2:0], trial_ge};

  assign scale_prod = pddf_pkg::PROD_W'(rem_r) * pddf_pkg::PROD_W'(pddf_pkg::FRAC_SCALE);

  // digit split
  assign hund_prod  = 16'(frac_r) * 16'(pddf_pkg::RECIP100);
  assign wtens_prod = 14'(whole_r) * 14'(pddf_pkg::RECIP10);
  assign ftens_prod = 14'(r100_r) * 14'(pddf_pkg::RECIP10);
  assign fones      = 4'(r100_r - 7'(ftens_r) * 7'd10);

  // bar cell is full while cell*1000 <= frac*cells
  assign cell_idx = pos_r - pddf_pkg::POS_W'(pddf_pkg::BAR_START);
  assign cell_lhs = pddf_pkg::BAR_PROD_W'(cell_idx)
                    * pddf_pkg::BAR_PROD_W'(pddf_pkg::FRAC_SCALE);
  assign cell_rhs = pddf_pkg::BAR_PROD_W'(frac_r)
                    * pddf_pkg::BAR_PROD_W'(pddf_pkg::BAR_CELLS);

  assign sign_ch = minus_r ? pddf_pkg::CH_MINUS : pddf_pkg::CH_PLUS;

  always_comb begin
    case (pos_r) inside
      pddf_pkg::POS_SIGN_A, pddf_pkg::POS_SIGN_B,
      pddf_pkg::POS_SIGN_C, pddf_pkg::POS_SIGN_D: frame_ch = sign_ch;
      pddf_pkg::POS_GAP, pddf_pkg::POS_UNIT_SP,
      pddf_pkg::POS_UNIT_SE: frame_ch = pddf_pkg::CH_SPACE;
      pddf_pkg::POS_TENS_W:  frame_ch = pddf_pkg::CH_ZERO + 8'(wtens_r);
      pddf_pkg::POS_ONES_W:  frame_ch = pddf_pkg::CH_ZERO + 8'(wones_r);
      pddf_pkg::POS_POINT:   frame_ch = pddf_pkg::CH_DOT;
      pddf_pkg::POS_HUND_F:  frame_ch = pddf_pkg::CH_ZERO + 8'(hund_r);
      pddf_pkg::POS_TENS_F:  frame_ch = pddf_pkg::CH_ZERO + 8'(ftens_r);
      pddf_pkg::POS_ONES_F:  frame_ch = pddf_pkg::CH_ZERO + 8'(fones);
      pddf_pkg::POS_UNIT_P:  frame_ch = pddf_pkg::CH_P;
      pddf_pkg::POS_UNIT_S:  frame_ch = pddf_pkg::CH_S;
      pddf_pkg::POS_UNIT_I:  frame_ch = pddf_pkg::CH_I;
      pddf_pkg::POS_NL:      frame_ch = pddf_pkg::CH_NL;
      default: frame_ch = (cell_lhs <= cell_rhs) ? pddf_pkg::CH_FULL
                                                 : pddf_pkg::CH_SPACE;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    cpu_nxt        = (cfg_valid && cfg_ready) ? cfg_data : cpu_r;
    baseline_nxt   = baseline_r;
    minus_nxt      = minus_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    whole_nxt      = whole_r;
    frac_nxt       = frac_r;
    hund_nxt       = hund_r;
    wtens_nxt      = wtens_r;
    wones_nxt      = wones_r;
    r100_nxt       = r100_r;
    ftens_nxt      = ftens_r;
    pos_nxt        = pos_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          baseline_nxt = base_sel;
          minus_nxt    = !sample_ge;
          dvd_nxt      = pddf_pkg::DVD_W'(delta);
          rem_nxt      = '0;
          cnt_nxt      = pddf_pkg::CNT_W'(pddf_pkg::DVD_W - 1);
          state_nxt    = S_DIV_W;
        end
      end
      S_DIV_W: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        if (cpu_zero || dvd_r > pddf_pkg::DVD_W'(pddf_pkg::WHOLE_MAX)) begin
          whole_nxt = pddf_pkg::WHOLE_W'(pddf_pkg::WHOLE_MAX);
        end else begin
          whole_nxt = dvd_r[pddf_pkg::WHOLE_W-1:0];
        end
        // remainder * 1000 < cpu << FRAC_W, so the quotient fits FRAC_W bits
        rem_nxt   = scale_prod[pddf_pkg::PROD_W-1:pddf_pkg::FRAC_W];
        dvd_nxt   = pddf_pkg::DVD_W'(scale_prod[pddf_pkg::FRAC_W-1:0])
                    << (pddf_pkg::DVD_W - pddf_pkg::FRAC_W);
        cnt_nxt   = pddf_pkg::CNT_W'(pddf_pkg::FRAC_W - 1);
        state_nxt = S_DIV_F;
      end
      S_DIV_F: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          frac_nxt  = cpu_zero ? pddf_pkg::FRAC_W'(pddf_pkg::FRAC_MAX)
                               : dvd_step[pddf_pkg::FRAC_W-1:0];
          state_nxt = S_DIG1;
        end
      end
      S_DIG1: begin
        hund_nxt  = hund_prod[pddf_pkg::RECIP100_SH+3:pddf_pkg::RECIP100_SH];
        wtens_nxt = wtens_prod[pddf_pkg::RECIP10_SH+3:pddf_pkg::RECIP10_SH];
        state_nxt = S_DIG2;
      end
      S_DIG2: begin
        r100_nxt  = 7'(frac_r - 10'(hund_r) * 10'd100);
        wones_nxt = 4'(whole_r - 7'(wtens_r) * 7'd10);
        state_nxt = S_DIG3;
      end
      S_DIG3: begin
        ftens_nxt = ftens_prod[pddf_pkg::RECIP10_SH+3:pddf_pkg::RECIP10_SH];
        pos_nxt   = '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = frame_ch;
          out_tlast_nxt  = (pos_r == pddf_pkg::POS_W'(pddf_pkg::CHARS - 1));
          if (pos_r == pddf_pkg::POS_W'(pddf_pkg::CHARS - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cpu_r        <= pddf_pkg::CPU_RESET;
      baseline_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cpu_r        <= cpu_nxt;
      baseline_r   <= baseline_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    minus_r     <= minus_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    whole_r     <= whole_nxt;
    frac_r      <= frac_nxt;
    hund_r      <= hund_nxt;
    wtens_r     <= wtens_nxt;
    wones_r     <= wones_nxt;
    r100_r      <= r100_nxt;
    ftens_r     <= ftens_nxt;
    pos_r       <= pos_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a frame is in progress");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_W || state_r == S_DIV_F) && !cpu_zero |-> rem_r < cpu_r)
    else $error("partial remainder not below divisor");

  a_frac_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV_F |-> cnt_r < pddf_pkg::CNT_W'(pddf_pkg::FRAC_W))
    else $error("fraction divide count out of range");

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pressure delta display formatter. Samples are
// sent on the input stream and every 33-character LCD frame that comes back
// is checked, character by character, against a frame built here from the
// tracked baseline and the current counts-per-unit scale. A directed set
// covers the baseline capture rules, sign, saturation, bar extremes and a
// zero scale. Random phases under several scale settings follow, with
// random idling on both streams.
// ----------------------------------------------------------------------------
module tb;

  localparam int PERIOD_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 39;

  typedef struct packed {
    logic [pddf_pkg::CHAR_W-1:0] code;
    logic                        last;
  } lcd_char_t;

  class lcd_frame_board;
    logic [pddf_pkg::SAMPLE_BITS-1:0] baseline;
    logic [pddf_pkg::CPU_W-1:0]       scale;
    lcd_char_t                        frame_q[$];
    int                               errors;

    function new();
      baseline = '0;
      scale    = pddf_pkg::CPU_RESET;
      errors   = 0;
    endfunction

    function void set_scale(logic [pddf_pkg::CPU_W-1:0] value);
      scale = value;
    endfunction

    function void push_char(logic [pddf_pkg::CHAR_W-1:0] code);
      frame_q.push_back('{code: code, last: 1'b0});
    endfunction

    // builds the frame for one accepted sample
    function void note_sample(logic func, logic [pddf_pkg::SAMPLE_BITS-1:0] sample);
      logic [pddf_pkg::SAMPLE_BITS-1:0] diff;
      logic [pddf_pkg::CHAR_W-1:0]      sign;
      longint unsigned                  q;
      longint unsigned                  whole;
      longint unsigned                  frac;
      longint unsigned                  seg;
      if (func || baseline == '0) begin
        baseline = sample;
      end
      if (sample >= baseline) begin
        sign = pddf_pkg::CH_PLUS;
        diff = sample - baseline;
      end else begin
        sign = pddf_pkg::CH_MINUS;
        diff = baseline - sample;
      end
      if (scale == '0) begin
        whole = pddf_pkg::WHOLE_MAX;
        frac  = pddf_pkg::FRAC_MAX;
      end else begin
        q     = (longint'(diff) * pddf_pkg::FRAC_SCALE) / longint'(scale);
        whole = q / pddf_pkg::FRAC_SCALE;
        frac  = q % pddf_pkg::FRAC_SCALE;
        if (whole > pddf_pkg::WHOLE_MAX) begin
          whole = pddf_pkg::WHOLE_MAX;
        end
      end
      push_char(sign);
      push_char(sign);
      push_char(pddf_pkg::CH_SPACE);
      push_char(pddf_pkg::CH_ZERO + pddf_pkg::CHAR_W'(whole / 10));
      push_char(pddf_pkg::CH_ZERO + pddf_pkg::CHAR_W'(whole % 10));
      push_char(pddf_pkg::CH_DOT);
      push_char(pddf_pkg::CH_ZERO + pddf_pkg::CHAR_W'(frac / 100));
      push_char(pddf_pkg::CH_ZERO + pddf_pkg::CHAR_W'((frac / 10) % 10));
      push_char(pddf_pkg::CH_ZERO + pddf_pkg::CHAR_W'(frac % 10));
      push_char(pddf_pkg::CH_SPACE);
      push_char(pddf_pkg::CH_P);
      push_char(pddf_pkg::CH_S);
      push_char(pddf_pkg::CH_I);
      push_char(pddf_pkg::CH_SPACE);
      push_char(sign);
      push_char(sign);
      push_char(pddf_pkg::CH_NL);
      seg = (frac * pddf_pkg::BAR_CELLS) / pddf_pkg::FRAC_SCALE;
      for (int i = 0; i < pddf_pkg::BAR_CELLS; i++) begin
        push_char((i <= seg) ? pddf_pkg::CH_FULL : pddf_pkg::CH_SPACE);
      end
      frame_q[frame_q.size() - 1].last = 1'b1;
    endfunction

    function void check_char(logic [pddf_pkg::CHAR_W-1:0] code, logic last);
      lcd_char_t want;
      if (frame_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected character: expected none, actual %h last %b",
                 $time, code, last);
        return;
      end
      want = frame_q.pop_front();
      if (code !== want.code) begin
        errors++;
        $display("%0t: char_code mismatch: expected %h, actual %h", $time, want.code, code);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, last);
      end
    endfunction

    function int pending();
      return frame_q.size();
    endfunction
  endclass

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [pddf_pkg::IN_DATA_W-1:0] in_tdata   = '0;
  logic [0:0]                     in_tuser   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [pddf_pkg::CHAR_W-1:0]    out_tdata;
  logic                           out_tlast;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [pddf_pkg::CPU_W-1:0]     cfg_data   = '0;

  lcd_frame_board board = new();
  bit             idle_on = 1'b0;
  int             stall_left = 0;
  int             cycles = 0;

  pressure_delta_display_formatter_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > PERIOD_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: check each transfer, stall in random bursts
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_char(out_tdata, out_tlast);
    end
    if (stall_left != 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8);
    end
    out_tready <= (stall_left == 0);
  end

  task automatic send_sample(logic func, logic [pddf_pkg::SAMPLE_BITS-1:0] sample);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pddf_pkg::IN_DATA_W'(sample);
    in_tuser  <= func;
    do @(posedge clk); while (!in_tready);
    board.note_sample(func, sample);
  endtask

  task automatic write_scale(logic [pddf_pkg::CPU_W-1:0] value);
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_scale(value);
  endtask

  initial begin
    logic [pddf_pkg::SAMPLE_BITS-1:0] base;
    longint                           span;
    longint                           delta;
    longint                           pick;
    logic [pddf_pkg::CPU_W-1:0]       scale;
    int                               mode;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default scale: unset baseline, capture, both signs, bar extremes
    base = 24'h100000;
    send_sample(1'b0, 24'h000000);
    send_sample(1'b0, base);
    send_sample(1'b0, base + 24'd318169);
    send_sample(1'b0, base - 24'd795423);
    send_sample(1'b0, 24'hFFFFFF);
    send_sample(1'b0, 24'h000000);
    send_sample(1'b1, 24'hFFFFFF);
    send_sample(1'b0, 24'h000000);
    send_sample(1'b1, 24'h000000);
    base = 24'h800000;
    send_sample(1'b0, base);
    send_sample(1'b0, base + 24'd318168);
    send_sample(1'b0, base + 24'd318);
    send_sample(1'b0, base - 24'd1000000);

    // unit scale: whole part saturation
    write_scale(24'd1);
    send_sample(1'b0, base + 24'd1);
    send_sample(1'b0, base + 24'd99);
    send_sample(1'b0, base + 24'd100);
    send_sample(1'b0, 24'h000000);

    // bar cell boundaries
    write_scale(24'd1000);
    send_sample(1'b0, base + 24'd62);
    send_sample(1'b0, base + 24'd63);
    send_sample(1'b0, base - 24'd999);

    write_scale(24'hFFFFFF);
    send_sample(1'b1, 24'hFFFFFF);
    send_sample(1'b0, 24'h000000);
    send_sample(1'b0, 24'h000001);

    // zero scale reads as full scale
    write_scale(24'd0);
    send_sample(1'b0, 24'h123456);
    send_sample(1'b0, 24'hFFFFFF);

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: scale = pddf_pkg::CPU_W'($urandom_range(1, 1000));
        1: scale = pddf_pkg::CPU_W'($urandom_range(1, 24'hFFFFFF));
        2: scale = pddf_pkg::CPU_RESET;
        3: scale = (p % 2 == 0) ? 24'd1 : 24'hFFFFFF;
        default: scale = pddf_pkg::CPU_W'($urandom_range(1000, 400000));
      endcase
      write_scale(scale);
      idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        mode = $urandom_range(0, 7);
        if (mode == 0 || board.baseline == '0) begin
          pick = $urandom_range(0, 24'hFFFFFF);
        end else begin
          case (mode)
            1, 2:    span = longint'(board.scale);
            7:       span = longint'(board.scale) * 120;
            default: span = longint'(board.scale) * 100;
          endcase
          if (span > 24'hFFFFFF) begin
            span = 24'hFFFFFF;
          end
          delta = $urandom_range(0, 32'(span));
          pick  = $urandom_range(0, 1) ? longint'(board.baseline) + delta
                                       : longint'(board.baseline) - delta;
          if (pick < 0) begin
            pick = 0;
          end else if (pick > 24'hFFFFFF) begin
            pick = 24'hFFFFFF;
          end
        end
        send_sample($urandom_range(0, 9) == 0, pddf_pkg::SAMPLE_BITS'(pick));
      end
    end

    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
